/* rtl/pvat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pvat_pkg;

  // Field and register widths fixed by the block's interface
  localparam int FC_W   = 11;
  localparam int CC_W   = 5;
  localparam int EP_W   = 16;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 2;
  localparam int X_W    = 9;
  localparam int ACC_W  = 64;

  // Input operations
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TRAIN = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FEATURE_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_CLASS_COUNT   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MAX_EPOCHS    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  class_label;
    logic [10:0] feature_index;
    logic [7:0]  word_count;
    logic        end_of_document;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic               converged;
    logic               last_result;
  } out_item_t;

  // Control beat into the dot-product unit
  typedef struct packed {
    logic valid;
    logic bias;
  } mac_ctl_t;

endpackage

`default_nettype wire

/* rtl/pvat_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pvat_in_if import pvat_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pvat_out_if import pvat_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/perceptron_one_vs_all_trainer_core.sv */
// Clear and load: one beat per cycle unless the result channel stalls; the result is
//   registered and valid in the cycle after the beat is accepted.
// Read weight: one weight memory read, then S_READ and back to idle for the next beat.
// Train: per class the weight row is zeroed, then per epoch and document a dot product
//   and, if misclassified, an update pass, each through the memories' single read port.
// Reset clears control state and the per-class row-valid bits (unvalidated rows read 0).
`timescale 1ns / 1ps
`default_nettype none

module perceptron_one_vs_all_trainer_core import pvat_pkg::*; #(
  parameter int MAX_DOCUMENTS = 1024,
  parameter int MAX_FEATURES  = 1024,
  parameter int MAX_CLASSES   = 16,
  parameter int WEIGHT_BITS   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  pvat_in_if.sink           in_i,
  pvat_out_if.source        out_o
);

  localparam int WB     = WEIGHT_BITS;
  localparam int ROW    = MAX_FEATURES + 1;
  localparam int WDEPTH = MAX_CLASSES * ROW;
  localparam int FDEPTH = MAX_DOCUMENTS * MAX_FEATURES;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int FAW    = $clog2(FDEPTH);
  localparam int LAW    = $clog2(MAX_DOCUMENTS);
  localparam int DCW    = $clog2(MAX_DOCUMENTS + 1);
  localparam int LPW    = $clog2(MAX_FEATURES + 1);
  localparam int SW     = $clog2(ROW);
  localparam int CW     = $clog2(MAX_CLASSES);
  localparam int FC_RST = (MAX_FEATURES < 1000) ? MAX_FEATURES : 1000;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_READ     = 9'b000000010,
    S_ZERO     = 9'b000000100,
    S_NEXT     = 9'b000001000,
    S_DOT      = 9'b000010000,
    S_DOT_WAIT = 9'b000100000,
    S_UPD      = 9'b001000000,
    S_UPD_WAIT = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [FC_W-1:0]  fc_q;
  logic [CC_W-1:0]  cc_q;
  logic [EP_W-1:0]  me_q;
  logic [DCW-1:0]   doc_cnt_q, doc_cnt_d;
  logic [LPW-1:0]   lp_q, lp_d;
  logic [FAW-1:0]   load_base_q, load_base_d;
  logic [MAX_CLASSES-1:0] rowv_q, rowv_d;
  logic [CC_W-1:0]  cls_q, cls_d;
  logic [WAW-1:0]   row_base_q, row_base_d;
  logic [SW-1:0]    sweep_q, sweep_d;
  logic [EP_W-1:0]  epoch_q, epoch_d;
  logic             changed_q, changed_d;
  logic             conv_q, conv_d;
  logic [DCW-1:0]   doc_q, doc_d;
  logic [FAW-1:0]   doc_base_q, doc_base_d;
  logic [FC_W-1:0]  i_q, i_d;
  logic             rd_ok_q, rd_ok_d;
  logic             out_v_q, out_v_d;
  out_item_t        out_q, out_d;

  // read pipeline stage that sits beside the memory outputs
  logic             s1v_q, s1v_d;
  logic             s1_bias_q, s1_bias_d;
  logic             s1_upd_q, s1_upd_d;
  logic [WAW-1:0]   s1_addr_q, s1_addr_d;

  // memories
  logic signed [WB-1:0]  wmem [WDEPTH];
  logic signed [X_W-1:0] fmem [FDEPTH];
  logic [3:0]            lmem [MAX_DOCUMENTS];
  logic signed [WB-1:0]  w_rd_q;
  logic signed [X_W-1:0] x_rd_q;
  logic [3:0]            lbl_rd_q;

  logic                  w_we;
  logic [WAW-1:0]        w_waddr, w_raddr;
  logic signed [WB-1:0]  w_wdata;
  logic                  f_we;
  logic [FAW-1:0]        f_waddr, f_raddr;
  logic signed [X_W-1:0] f_wdata;
  logic                  l_we;
  logic [LAW-1:0]        l_waddr, l_raddr;

  logic                  accept, out_free, issue, issue_bias, y;
  logic                  mac_clr, mac_busy, upd_need;
  mac_ctl_t              mac_ctl;
  logic signed [ACC_W-1:0] acc;
  logic signed [X_W:0]   x_ext, term;
  logic signed [WB:0]    upd_sum;
  logic signed [WB-1:0]  upd_sat;
  logic signed [63:0]    w64;
  logic signed [31:0]    rd_sat;
  logic [SW-1:0]         rd_slot;
  in_item_t              item;

  assign item     = in_i.data;
  assign accept   = in_i.valid & in_i.ready;
  assign out_free = !out_v_q | out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // this document is a positive example for the current class
  assign y = (32'(lbl_rd_q) == 32'(cls_q));
  assign upd_need = y ? (acc <= 0) : (acc >= 0);

  // write-back value of the perceptron update
  always_comb begin
    x_ext = {x_rd_q[X_W-1], x_rd_q};
    if (s1_bias_q) begin
      term = y ? (X_W+1)'(1) : '1;
    end else begin
      term = y ? x_ext : -x_ext;
    end
    upd_sum = (WB+1)'(w_rd_q) + (WB+1)'(term);
    if (upd_sum[WB] != upd_sum[WB-1]) begin
      upd_sat = upd_sum[WB] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}};
    end else begin
      upd_sat = upd_sum[WB-1:0];
    end
  end

  // read-back saturation to 32 bits
  always_comb begin
    w64 = 64'(w_rd_q);
    if (w64 > 64'sh0000_0000_7FFF_FFFF) begin
      rd_sat = 32'sh7FFF_FFFF;
    end else if (w64 < -64'sh0000_0000_8000_0000) begin
      rd_sat = -32'sh8000_0000;
    end else begin
      rd_sat = w64[31:0];
    end
  end

  assign rd_slot = (item.feature_index == fc_q) ? SW'(MAX_FEATURES) : SW'(item.feature_index);

  // main sequencer
  always_comb begin
    state_d     = state_q;
    doc_cnt_d   = doc_cnt_q;
    lp_d        = lp_q;
    load_base_d = load_base_q;
    rowv_d      = rowv_q;
    cls_d       = cls_q;
    row_base_d  = row_base_q;
    sweep_d     = sweep_q;
    epoch_d     = epoch_q;
    changed_d   = changed_q;
    conv_d      = conv_q;
    doc_d       = doc_q;
    doc_base_d  = doc_base_q;
    i_d         = i_q;
    rd_ok_d     = rd_ok_q;
    out_v_d     = out_v_q & !out_o.ready;
    out_d       = out_q;
    issue       = 1'b0;
    mac_clr     = 1'b0;
    w_we        = 1'b0;
    w_waddr     = s1_addr_q;
    w_wdata     = upd_sat;
    f_we        = 1'b0;
    f_waddr     = load_base_q + FAW'(lp_q);
    f_wdata     = (item.word_count == 8'd0) ? '1 : X_W'(item.word_count);
    l_we        = 1'b0;
    l_waddr     = LAW'(doc_cnt_q);
    l_raddr     = LAW'(doc_q);
    issue_bias  = (i_q == '0);
    w_raddr     = row_base_q + (issue_bias ? WAW'(MAX_FEATURES) : WAW'(i_q - FC_W'(1)));
    f_raddr     = doc_base_q + FAW'(i_q - FC_W'(1));

    // update write-back of the previous read
    if (s1v_q && s1_upd_q) begin
      w_we = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_d = '{status: STAT_OK, value: '0, converged: 1'b0, last_result: 1'b1};
          unique case (op_e'(item.operation))
            OP_CLEAR: begin
              doc_cnt_d   = '0;
              lp_d        = '0;
              load_base_d = '0;
              out_v_d     = 1'b1;
            end
            OP_LOAD: begin
              out_v_d = 1'b1;
              if (doc_cnt_q == DCW'(MAX_DOCUMENTS)) begin
                out_d.status = STAT_FULL;
              end else begin
                if (lp_q < LPW'(MAX_FEATURES)) begin
                  f_we = 1'b1;
                end else begin
                  out_d.status = STAT_RANGE;
                end
                l_we = 1'b1;
                if (item.end_of_document) begin
                  doc_cnt_d   = doc_cnt_q + DCW'(1);
                  lp_d        = '0;
                  load_base_d = load_base_q + FAW'(MAX_FEATURES);
                end else if (lp_q < LPW'(MAX_FEATURES)) begin
                  lp_d = lp_q + LPW'(1);
                end
              end
            end
            OP_TRAIN: begin
              cls_d      = '0;
              row_base_d = '0;
              sweep_d    = '0;
              state_d    = S_ZERO;
            end
            OP_READ: begin
              if (32'(item.class_label) >= MAX_CLASSES || item.feature_index > fc_q) begin
                out_d.status = STAT_RANGE;
                out_v_d      = 1'b1;
              end else begin
                w_raddr = WAW'(item.class_label) * WAW'(ROW) + WAW'(rd_slot);
                rd_ok_d = rowv_q[CW'(item.class_label)];
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        out_v_d = 1'b1;
        out_d   = '{status: STAT_OK, value: rd_ok_q ? rd_sat : '0,
                    converged: 1'b0, last_result: 1'b1};
        state_d = S_IDLE;
      end
      S_ZERO: begin
        // clear this class's weight row, one entry a cycle
        w_we    = 1'b1;
        w_waddr = row_base_q + WAW'(sweep_q);
        w_wdata = '0;
        if (sweep_q == SW'(ROW - 1)) begin
          rowv_d[CW'(cls_q)] = 1'b1;
          epoch_d    = EP_W'(1);
          changed_d  = 1'b0;
          doc_d      = '0;
          doc_base_d = '0;
          state_d    = S_NEXT;
        end else begin
          sweep_d = sweep_q + SW'(1);
        end
      end
      S_NEXT: begin
        if (doc_q < doc_cnt_q) begin
          i_d     = '0;
          mac_clr = 1'b1;
          state_d = S_DOT;
        end else if (!changed_q) begin
          conv_d  = 1'b1;
          state_d = S_EMIT;
        end else if (epoch_q == me_q) begin
          conv_d  = 1'b0;
          state_d = S_EMIT;
        end else begin
          epoch_d    = epoch_q + EP_W'(1);
          changed_d  = 1'b0;
          doc_d      = '0;
          doc_base_d = '0;
        end
      end
      S_DOT: begin
        issue = 1'b1;
        if (i_q == fc_q) begin
          state_d = S_DOT_WAIT;
        end else begin
          i_d = i_q + FC_W'(1);
        end
      end
      S_DOT_WAIT: begin
        if (!s1v_q && !mac_busy) begin
          if (upd_need) begin
            changed_d = 1'b1;
            i_d       = '0;
            state_d   = S_UPD;
          end else begin
            doc_d      = doc_q + DCW'(1);
            doc_base_d = doc_base_q + FAW'(MAX_FEATURES);
            state_d    = S_NEXT;
          end
        end
      end
      S_UPD: begin
        issue = 1'b1;
        if (i_q == fc_q) begin
          state_d = S_UPD_WAIT;
        end else begin
          i_d = i_q + FC_W'(1);
        end
      end
      S_UPD_WAIT: begin
        doc_d      = doc_q + DCW'(1);
        doc_base_d = doc_base_q + FAW'(MAX_FEATURES);
        state_d    = S_NEXT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_v_d = 1'b1;
          out_d   = '{status: STAT_OK, value: 32'(epoch_q), converged: conv_q,
                      last_result: (cls_q + CC_W'(1) == cc_q)};
          if (cls_q + CC_W'(1) == cc_q) begin
            state_d = S_IDLE;
          end else begin
            cls_d      = cls_q + CC_W'(1);
            row_base_d = row_base_q + WAW'(ROW);
            sweep_d    = '0;
            state_d    = S_ZERO;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    s1v_d     = issue;
    s1_bias_d = issue_bias;
    s1_upd_d  = (state_q == S_UPD);
    s1_addr_d = w_raddr;
  end

  assign mac_ctl.valid = s1v_q & !s1_upd_q;
  assign mac_ctl.bias  = s1_bias_q;

  pvat_mac #(
    .WEIGHT_BITS(WB)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .clr_i (mac_clr),
    .w_i   (w_rd_q),
    .x_i   (x_rd_q),
    .acc_o (acc),
    .busy_o(mac_busy)
  );

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rd_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    x_rd_q <= fmem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      lmem[l_waddr] <= item.class_label;
    end
    lbl_rd_q <= lmem[l_raddr];
  end

  // configuration registers, clamped into range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= FC_W'(FC_RST);
      cc_q <= CC_W'(2);
      me_q <= EP_W'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FEATURE_COUNT: begin
          if (cfg_data_i[FC_W-1:0] == '0) begin
            fc_q <= FC_W'(1);
          end else if (32'(cfg_data_i[FC_W-1:0]) > MAX_FEATURES) begin
            fc_q <= FC_W'(MAX_FEATURES);
          end else begin
            fc_q <= cfg_data_i[FC_W-1:0];
          end
        end
        REG_CLASS_COUNT: begin
          if (cfg_data_i[CC_W-1:0] == '0) begin
            cc_q <= CC_W'(1);
          end else if (32'(cfg_data_i[CC_W-1:0]) > MAX_CLASSES) begin
            cc_q <= CC_W'(MAX_CLASSES);
          end else begin
            cc_q <= cfg_data_i[CC_W-1:0];
          end
        end
        REG_MAX_EPOCHS: begin
          me_q <= (cfg_data_i == '0) ? EP_W'(1) : cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      doc_cnt_q   <= '0;
      lp_q        <= '0;
      load_base_q <= '0;
      rowv_q      <= '0;
      cls_q       <= '0;
      row_base_q  <= '0;
      sweep_q     <= '0;
      epoch_q     <= '0;
      changed_q   <= 1'b0;
      conv_q      <= 1'b0;
      doc_q       <= '0;
      doc_base_q  <= '0;
      i_q         <= '0;
      rd_ok_q     <= 1'b0;
      out_v_q     <= 1'b0;
      s1v_q       <= 1'b0;
      s1_upd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      doc_cnt_q   <= doc_cnt_d;
      lp_q        <= lp_d;
      load_base_q <= load_base_d;
      rowv_q      <= rowv_d;
      cls_q       <= cls_d;
      row_base_q  <= row_base_d;
      sweep_q     <= sweep_d;
      epoch_q     <= epoch_d;
      changed_q   <= changed_d;
      conv_q      <= conv_d;
      doc_q       <= doc_d;
      doc_base_q  <= doc_base_d;
      i_q         <= i_d;
      rd_ok_q     <= rd_ok_d;
      out_v_q     <= out_v_d;
      s1v_q       <= s1v_d;
      s1_upd_q    <= s1_upd_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    s1_bias_q <= s1_bias_d;
    s1_addr_q <= s1_addr_d;
  end

  // weight write-back only happens during the update pass
  a_wb_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1v_q && s1_upd_q) |-> (state_q == S_UPD || state_q == S_UPD_WAIT))
    else $error("weight write-back outside update pass");

  // a dot product only runs on a loaded document
  a_doc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DOT) |-> (doc_q < doc_cnt_q))
    else $error("training past loaded documents");

  // reported epoch count stays within the limit
  a_epoch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (epoch_q != '0 && epoch_q <= me_q))
    else $error("epoch count out of range");

  // row clear never overlaps a pending write-back
  a_zero_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ZERO) |-> !s1v_q)
    else $error("row clear collides with write-back");

endmodule

`default_nettype wire

/* rtl/pvat_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvat_mac import pvat_pkg::*; #(
  parameter int WEIGHT_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctl_t                ctl_i,
  input  logic                    clr_i,
  input  logic signed [WEIGHT_BITS-1:0] w_i,
  input  logic signed [X_W-1:0]   x_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    busy_o
);

  localparam int PW = WEIGHT_BITS + X_W;
  localparam logic signed [ACC_W:0] ACC_HI = (ACC_W+1)'(64'sh4000_0000_0000_0000);
  localparam logic signed [ACC_W:0] ACC_LO = -ACC_HI;

  logic                    va_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [PW-1:0]    prod_d;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W:0]   sum;

  // stage A: product, bias passes straight through
  always_comb begin
    if (ctl_i.bias) begin
      prod_d = PW'(w_i);
    end else begin
      prod_d = PW'(w_i) * PW'(x_i);
    end
  end

  // stage B: saturating accumulate
  always_comb begin
    sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(prod_q);
    if (clr_i) begin
      acc_d = '0;
    end else if (!va_q) begin
      acc_d = acc_q;
    end else if (sum > ACC_HI) begin
      acc_d = ACC_W'(ACC_HI);
    end else if (sum < ACC_LO) begin
      acc_d = ACC_W'(ACC_LO);
    end else begin
      acc_d = ACC_W'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      va_q  <= ctl_i.valid;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = va_q;

endmodule

`default_nettype wire

/* verif/pvat_train_check.sv */
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts every result beat
// of the trainer and compares it with what comes out.
module pvat_train_check import pvat_pkg::*; #(
  parameter int MAX_DOCUMENTS = 1024,
  parameter int MAX_FEATURES  = 1024,
  parameter int MAX_CLASSES   = 16,
  parameter int WEIGHT_BITS   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  pvat_in_if                in_i,
  pvat_out_if               out_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                train_runs_o,
  output int                results_seen_o
);

  localparam longint ACC_LIM = longint'(1) <<< 62;

  // Shadow copy of the block's stores and registers
  logic signed [X_W-1:0] feat_mem [MAX_DOCUMENTS*MAX_FEATURES];
  logic [3:0]            label_mem [MAX_DOCUMENTS];
  longint                weight_mem [MAX_CLASSES][MAX_FEATURES+1];
  int unsigned           doc_count, load_pos, n_features, n_classes, epoch_limit;

  out_item_t expected_results [$];

  initial begin
    fail_count_o   = 0;
    pending_o      = 0;
    train_runs_o   = 0;
    results_seen_o = 0;
    doc_count      = 0;
    load_pos       = 0;
    n_features     = 1000;
    n_classes      = 2;
    epoch_limit    = 1000;
    foreach (weight_mem[c, f]) weight_mem[c][f] = 0;
    foreach (label_mem[d]) label_mem[d] = '0;
  end

  task automatic queue_expected(out_item_t r);
    expected_results = {expected_results, r};
  endtask

  function automatic longint sat_weight(longint v);
    longint hi;
    hi = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint sat_acc(longint v);
    if (v > ACC_LIM) return ACC_LIM;
    if (v < -ACC_LIM) return -ACC_LIM;
    return v;
  endfunction

  function automatic out_item_t make_result(logic [1:0] st, longint val, logic conv,
                                            logic last);
    out_item_t r;
    r.status      = st;
    r.value       = val[31:0];
    r.converged   = conv;
    r.last_result = last;
    return r;
  endfunction

  // One class against all others; returns epochs used, flags convergence
  task automatic train_one_class(int c, output int unsigned epochs, output logic conv);
    longint      acc, y;
    logic        changed;
    int unsigned base;
    for (int f = 0; f <= MAX_FEATURES; f++) weight_mem[c][f] = 0;
    conv   = 1'b0;
    epochs = 0;
    while (epochs < epoch_limit) begin
      changed = 1'b0;
      epochs++;
      for (int unsigned d = 0; d < doc_count; d++) begin
        base = d * MAX_FEATURES;
        y    = (label_mem[d] == c) ? 1 : -1;
        acc  = weight_mem[c][MAX_FEATURES];
        for (int unsigned f = 0; f < n_features; f++)
          acc = sat_acc(acc + weight_mem[c][f] * longint'(feat_mem[base + f]));
        if (y * acc <= 0) begin
          for (int unsigned f = 0; f < n_features; f++)
            weight_mem[c][f] = sat_weight(weight_mem[c][f] + y * longint'(feat_mem[base + f]));
          weight_mem[c][MAX_FEATURES] = sat_weight(weight_mem[c][MAX_FEATURES] + y);
          changed = 1'b1;
        end
      end
      if (!changed) begin
        conv = 1'b1;
        break;
      end
    end
  endtask

  task automatic predict_beat(in_item_t it);
    logic [1:0]  st;
    int unsigned epochs, slot;
    logic        conv;
    case (op_e'(it.operation))
      OP_CLEAR: begin
        doc_count = 0;
        load_pos  = 0;
        queue_expected(make_result(STAT_OK, 0, 1'b0, 1'b1));
      end
      OP_LOAD: begin
        if (doc_count >= MAX_DOCUMENTS) begin
          queue_expected(make_result(STAT_FULL, 0, 1'b0, 1'b1));
        end else begin
          st = STAT_OK;
          if (load_pos < MAX_FEATURES)
            feat_mem[doc_count * MAX_FEATURES + load_pos] =
              (it.word_count == 0) ? -9'sd1 : X_W'($signed({1'b0, it.word_count}));
          else
            st = STAT_RANGE;
          label_mem[doc_count] = it.class_label;
          if (it.end_of_document) begin
            doc_count++;
            load_pos = 0;
          end else if (load_pos < MAX_FEATURES) begin
            load_pos++;
          end
          queue_expected(make_result(st, 0, 1'b0, 1'b1));
        end
      end
      OP_TRAIN: begin
        train_runs_o++;
        for (int c = 0; c < n_classes; c++) begin
          train_one_class(c, epochs, conv);
          queue_expected(make_result(STAT_OK, epochs, conv, c == n_classes - 1));
        end
      end
      default: begin
        if (it.class_label >= MAX_CLASSES || it.feature_index > n_features) begin
          queue_expected(make_result(STAT_RANGE, 0, 1'b0, 1'b1));
        end else begin
          slot = (it.feature_index == n_features) ? MAX_FEATURES : it.feature_index;
          queue_expected(make_result(STAT_OK,
            weight_mem[it.class_label][slot], 1'b0, 1'b1));
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    results_seen_o++;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result beat, status", got.status, -1);
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.value !== want.value) report_mismatch("value", got.value, want.value);
    if (got.converged !== want.converged)
      report_mismatch("converged", got.converged, want.converged);
    if (got.last_result !== want.last_result)
      report_mismatch("last_result", got.last_result, want.last_result);
  endtask

  // Register writes saturate into their legal ranges
  task automatic apply_config(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    int unsigned v;
    case (idx)
      REG_FEATURE_COUNT: begin
        v = data[FC_W-1:0];
        n_features = (v < 1) ? 1 : (v > MAX_FEATURES) ? MAX_FEATURES : v;
      end
      REG_CLASS_COUNT: begin
        v = data[CC_W-1:0];
        n_classes = (v < 1) ? 1 : (v > MAX_CLASSES) ? MAX_CLASSES : v;
      end
      REG_MAX_EPOCHS: begin
        v = data[EP_W-1:0];
        epoch_limit = (v < 1) ? 1 : v;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) apply_config(cfg_idx_i, cfg_data_i);
      if (in_i.valid && in_i.ready) predict_beat(in_i.data);
      if (out_i.valid && out_i.ready) compare_result(out_i.data);
      pending_o = expected_results.size();
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import pvat_pkg::*;

  localparam int MAX_DOCUMENTS = 1024;
  localparam int MAX_FEATURES  = 1024;
  localparam int IDLE_LIMIT    = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  int fail_count, pending, train_runs, results_seen;
  int beats_sent = 0;
  int burst_left = 0;
  int gap_max = 4;
  int cur_features = 1000;

  pvat_in_if  in_ch ();
  pvat_out_if out_ch ();

  always #2 clk_i = ~clk_i;

  perceptron_one_vs_all_trainer_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  pvat_train_check #(.MAX_DOCUMENTS(MAX_DOCUMENTS), .MAX_FEATURES(MAX_FEATURES)) i_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_i          (in_ch),
    .out_i         (out_ch),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .train_runs_o  (train_runs),
    .results_seen_o(results_seen)
  );

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver back-pressure: the mode is changed at random
  int ready_mode = 0;
  int mode_left  = 0;
  int stall_cnt  = 0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    stall_cnt++;
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 1) == 1);
      default: out_ch.ready <= (stall_cnt % 5 != 0);
    endcase
  end

  // Watchdog on cycles without any beat
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending", idle_cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_beat(op_e op, logic [3:0] lbl, logic [10:0] idx, logic [7:0] wc,
                           logic eod);
    in_item_t it;
    int       gap;
    it.operation       = op;
    it.class_label     = lbl;
    it.feature_index   = idx;
    it.word_count      = wc;
    it.end_of_document = eod;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FEATURE_COUNT)
      cur_features = (data[FC_W-1:0] == 0) ? 1 :
                     (data[FC_W-1:0] > MAX_FEATURES) ? MAX_FEATURES : data[FC_W-1:0];
  endtask

  function automatic logic [7:0] rand_count();
    return ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
  endfunction

  // A whole document: n feature beats, the last one closing it
  task automatic load_doc(logic [3:0] lbl, int n);
    for (int f = 0; f < n; f++) send_beat(OP_LOAD, lbl, 11'($urandom), rand_count(), f == n - 1);
  endtask

  task automatic read_rand(int n_cls);
    int idx;
    idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, cur_features);
    send_beat(OP_READ, 4'($urandom_range(0, n_cls - 1)), 11'(idx), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    int n_cls, n_docs;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: reads around the bias slot at reset size, training an empty set
    send_beat(OP_READ, 4'd0, 11'd0, 8'd0, 1'b0);
    send_beat(OP_READ, 4'd15, 11'd1000, 8'd0, 1'b0);
    send_beat(OP_READ, 4'd1, 11'd1001, 8'd0, 1'b0);
    send_beat(OP_READ, 4'd3, 11'd2047, 8'hff, 1'b1);
    send_beat(OP_TRAIN, 4'd0, 11'd0, 8'd0, 1'b0);
    send_beat(OP_LOAD, 4'd7, 11'd0, 8'd0, 1'b0);
    send_beat(OP_CLEAR, 4'd0, 11'd0, 8'd0, 1'b0);

    // Registers saturated at both ends, empty set trained at the widest vector
    write_reg(REG_FEATURE_COUNT, 16'h07ff);
    write_reg(REG_CLASS_COUNT, 16'd0);
    write_reg(REG_MAX_EPOCHS, 16'd0);
    send_beat(OP_TRAIN, 4'd0, 11'd0, 8'd0, 1'b0);
    send_beat(OP_READ, 4'd0, 11'd1024, 8'd0, 1'b0);
    send_beat(OP_READ, 4'd0, 11'd1023, 8'd0, 1'b0);
    send_beat(OP_READ, 4'd0, 11'd1025, 8'd0, 1'b0);

    // Longest epoch limit, all classes, one document so every class converges
    write_reg(REG_FEATURE_COUNT, 16'd3);
    write_reg(REG_CLASS_COUNT, 16'd31);
    write_reg(REG_MAX_EPOCHS, 16'hffff);
    load_doc(4'd5, 3);
    send_beat(OP_TRAIN, 4'd0, 11'd0, 8'd0, 1'b0);
    for (int c = 4; c < 7; c++) send_beat(OP_READ, 4'(c), 11'd3, 8'd0, 1'b0);
    send_beat(OP_CLEAR, 4'd0, 11'd0, 8'd0, 1'b0);

    // Random phases: noise, then a well-formed dataset, training and read-back
    for (int p = 0; p < 14; p++) begin
      gap_max = (p % 3 == 0) ? 0 : 6;
      n_cls = $urandom_range(1, 16);
      write_reg(REG_FEATURE_COUNT, 16'($urandom_range(1, 6)));
      write_reg(REG_CLASS_COUNT, 16'(n_cls));
      write_reg(REG_MAX_EPOCHS, 16'($urandom_range(1, 12)));
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(0, 2))
          0: read_rand(16);
          1: send_beat(OP_LOAD, 4'($urandom), 11'($urandom), rand_count(), 1'($urandom));
          default: send_beat(OP_CLEAR, 4'($urandom), 11'($urandom), 8'($urandom), 1'($urandom));
        endcase
      end
      send_beat(OP_CLEAR, 4'd0, 11'd0, 8'd0, 1'b0);
      n_docs = $urandom_range(1, 4);
      for (int d = 0; d < n_docs; d++) load_doc(4'($urandom_range(0, n_cls)), cur_features);
      send_beat(OP_TRAIN, 4'($urandom), 11'($urandom), 8'($urandom), 1'($urandom));
      repeat (12) read_rand(n_cls);
    end

    drain();
    $display("covered %0d input beats, %0d training runs, %0d result beats checked",
             beats_sent, train_runs, results_seen);
    $display("bias reads, out-of-range reads, register saturation and convergence exercised");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
